// ===== src/btsc_pkg.sv =====
// Shared types, constants and helpers for the byte table stream cipher.
// Depends on nothing; every other source file imports it.
`default_nettype none

package btsc_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BYTES   = 32;
    localparam int WORD_W      = 64;
    localparam int KEY_WORDS   = 4;
    localparam int NONCE_WORDS = 2;
    localparam int NONCE_MAX   = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int SPREAD_LEN  = TABLE_DEPTH - KEY_BYTES;
    localparam int HALF_TABLE  = TABLE_DEPTH / 2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0      = 3'd0,
        REG_KEY1      = 3'd1,
        REG_KEY2      = 3'd2,
        REG_KEY3      = 3'd3,
        REG_NONCE0    = 3'd4,
        REG_NONCE1    = 3'd5,
        REG_NONCE_LEN = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        CMD_REKEY = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    // Requests from the controller to the table: one write and two reads.
    typedef struct packed {
        logic  clear;
        logic  we;
        byte_t wr_addr;
        byte_t wr_data;
        byte_t rd_addr_a;
        byte_t rd_addr_b;
    } tbl_req_t;

    typedef struct packed {
        byte_t rd_data_a;
        byte_t rd_data_b;
    } tbl_rsp_t;

    // Picks byte sel of a 64-bit word, byte 0 in bits 7:0.
    function automatic byte_t word_byte(input logic [WORD_W-1:0] w, input logic [2:0] sel);
        return w[sel*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ===== src/btsc_stream_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on btsc_pkg for the byte type.
`default_nettype none

interface btsc_item_if import btsc_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    byte_t data_in;

    modport source (output valid, output cmd, output data_in, input ready);
    modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface btsc_result_if import btsc_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// ===== src/byte_table_stream_cipher.sv =====
// Top level of the byte table stream cipher: configuration registers, result
// register and the controller and table. Depends on btsc_pkg, the channel
// interfaces, btsc_ctrl and btsc_table.
//
// Use: configuration registers (key words 0 to 3, nonce words 0 and 1,
// nonce length) are written through cfg_we, cfg_index and cfg_data while the
// block is idle; an index beyond the list is ignored. Input transactions on
// the item channel carry a command and a data byte; a rekey command gives no
// result, a data command gives one result transaction on the result channel.
// A data byte takes a read step, which fetches the current table entry and its
// neighbour from the single table RAM, and a write step, which writes the
// updated entry back. A new transaction is accepted in the write step of the
// previous byte, and the result is loaded into the output register as that
// write step completes. A rekey walks every setup pass through the RAM, with a
// read and a write step per step of the pass, during which no transaction is
// accepted. Reset clears the table through per-entry valid bits at once, so
// the block is ready as soon as reset is released. When the receiver stalls,
// the result waits in its output register; one more data byte may enter and
// then holds in its write step until space frees.
`default_nettype none

module byte_table_stream_cipher import btsc_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    btsc_item_if.sink                 item,
    btsc_result_if.source             result
);

    logic [KEY_WORDS-1:0][WORD_W-1:0]   key_reg, key_next;
    logic [NONCE_WORDS-1:0][WORD_W-1:0] nonce_reg, nonce_next;
    logic [LEN_W-1:0]                   nonce_len_reg, nonce_len_next;

    logic  result_valid_reg, result_valid_next;
    byte_t result_data_reg, result_data_next;

    logic     res_free;
    logic     res_load;
    byte_t    res_data;
    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;

    // Configuration writes; the register index selects one of the words.
    always_comb
    begin
        key_next       = key_reg;
        nonce_next     = nonce_reg;
        nonce_len_next = nonce_len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0:      key_next[0]    = cfg_data;
                REG_KEY1:      key_next[1]    = cfg_data;
                REG_KEY2:      key_next[2]    = cfg_data;
                REG_KEY3:      key_next[3]    = cfg_data;
                REG_NONCE0:    nonce_next[0]  = cfg_data;
                REG_NONCE1:    nonce_next[1]  = cfg_data;
                REG_NONCE_LEN: nonce_len_next = cfg_data[LEN_W-1:0];
                default:       nonce_len_next = nonce_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nonce_reg     <= '0;
            nonce_len_reg <= LEN_W'(NONCE_MAX);
        end
        else
        begin
            key_reg       <= key_next;
            nonce_reg     <= nonce_next;
            nonce_len_reg <= nonce_len_next;
        end
    end

    // Result register: a finished byte may replace the one being taken.
    assign res_free = !result_valid_reg || result.ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_data_next  = result_data_reg;
        if (res_load)
        begin
            result_valid_next = 1'b1;
            result_data_next  = res_data;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_data_reg <= result_data_next;
    end

    assign result.valid    = result_valid_reg;
    assign result.data_out = result_data_reg;

    btsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .item_data  (item.data_in),
        .item_ready (item.ready),
        .res_free   (res_free),
        .res_load   (res_load),
        .res_data   (res_data),
        .key        (key_reg),
        .nonce      (nonce_reg),
        .nonce_len  (nonce_len_reg),
        .tbl_req    (tbl_req),
        .tbl_rsp    (tbl_rsp)
    );

    btsc_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

endmodule

`default_nettype wire

// ===== src/btsc_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Depends on btsc_pkg for the default geometry.
`default_nettype none

module btsc_ram import btsc_pkg::*; #(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = TABLE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== src/btsc_table.sv =====
// Mixing table: the generic RAM plus one valid bit per entry.
// Depends on btsc_pkg and btsc_ram. Entries that are not valid read as zero.
`default_nettype none

module btsc_table import btsc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_req_t req,
    output tbl_rsp_t      rsp
);

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic                   valid_a_reg;
    logic                   valid_b_reg;
    byte_t                  ram_a;
    byte_t                  ram_b;

    btsc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk       (clk),
        .we        (req.we),
        .wr_addr   (req.wr_addr),
        .wr_data   (req.wr_data),
        .rd_addr_a (req.rd_addr_a),
        .rd_addr_b (req.rd_addr_b),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.we)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    // The valid lookup is registered alongside the RAM read so both line up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            valid_a_reg <= valid_reg[req.rd_addr_a];
            valid_b_reg <= valid_reg[req.rd_addr_b];
        end
    end

    assign rsp.rd_data_a = valid_a_reg ? ram_a : '0;
    assign rsp.rd_data_b = valid_b_reg ? ram_b : '0;

endmodule

`default_nettype wire

// ===== src/btsc_ctrl.sv =====
// Sequencer and datapath: read, modify and write back the mixing table for
// rekey passes and data bytes. Depends on btsc_pkg; drives btsc_table.
`default_nettype none

module btsc_ctrl import btsc_pkg::*; (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    input  wire logic                               item_cmd,
    input  wire byte_t                              item_data,
    output logic                                    item_ready,
    input  wire logic                               res_free,
    output logic                                    res_load,
    output byte_t                                   res_data,
    input  wire logic [KEY_WORDS-1:0][WORD_W-1:0]   key,
    input  wire logic [NONCE_WORDS-1:0][WORD_W-1:0] nonce,
    input  wire logic [LEN_W-1:0]                   nonce_len,
    output tbl_req_t                                tbl_req,
    input  wire tbl_rsp_t                           tbl_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    typedef enum logic [6:0] {
        PH_KEY    = 7'b0000001,
        PH_STIR1  = 7'b0000010,
        PH_NONCE  = 7'b0000100,
        PH_STIR2  = 7'b0001000,
        PH_SPREAD = 7'b0010000,
        PH_FINAL  = 7'b0100000,
        PH_DATA   = 7'b1000000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    byte_t  step_reg, step_next;
    byte_t  mix_reg, mix_next;
    byte_t  pos_reg, pos_next;
    byte_t  data_reg, data_next;

    logic [LEN_W-1:0] len_eff;
    byte_t            key_b;
    byte_t            nonce_b;
    byte_t            ta;
    byte_t            tb;
    byte_t            new_val;
    byte_t            mix_upd;
    byte_t            ks;
    logic             last_step;
    logic             accept;

    assign len_eff = (nonce_len > LEN_W'(NONCE_MAX)) ? LEN_W'(NONCE_MAX) : nonce_len;
    assign key_b   = word_byte(key[step_reg[4:3]], step_reg[2:0]);
    assign nonce_b = word_byte(nonce[step_reg[3]], step_reg[2:0]);
    assign ta      = tbl_rsp.rd_data_a;
    assign tb      = tbl_rsp.rd_data_b;

    // Table addresses; they hold through the read and write cycles of a step.
    always_comb
    begin
        tbl_req.rd_addr_a = step_reg;
        tbl_req.rd_addr_b = step_reg;
        tbl_req.wr_addr   = step_reg;
        unique case (phase_reg)
            PH_KEY, PH_NONCE:
            begin
                tbl_req.rd_addr_a = step_reg;
                tbl_req.rd_addr_b = step_reg;
                tbl_req.wr_addr   = step_reg;
            end
            PH_STIR1, PH_STIR2:
            begin
                tbl_req.rd_addr_a = step_reg & byte_t'(KEY_BYTES - 1);
                tbl_req.rd_addr_b = step_reg & byte_t'(KEY_BYTES - 1);
                tbl_req.wr_addr   = step_reg & byte_t'(KEY_BYTES - 1);
            end
            PH_SPREAD:
            begin
                tbl_req.rd_addr_a = step_reg;
                tbl_req.rd_addr_b = (step_reg == byte_t'(SPREAD_LEN - 1)) ? '0
                                                                          : step_reg + 8'd1;
                tbl_req.wr_addr   = step_reg + byte_t'(KEY_BYTES);
            end
            PH_FINAL:
            begin
                tbl_req.rd_addr_a = step_reg;
                tbl_req.rd_addr_b = step_reg + byte_t'(HALF_TABLE);
                tbl_req.wr_addr   = step_reg;
            end
            PH_DATA:
            begin
                tbl_req.rd_addr_a = pos_reg;
                tbl_req.rd_addr_b = pos_reg + 8'd1;
                tbl_req.wr_addr   = pos_reg;
            end
            default:
            begin
                tbl_req.rd_addr_a = step_reg;
                tbl_req.rd_addr_b = step_reg;
                tbl_req.wr_addr   = step_reg;
            end
        endcase
    end

    // New table entry and mixing register for the current step.
    always_comb
    begin
        new_val   = ta + tb + mix_reg;
        mix_upd   = mix_reg + new_val + step_reg;
        last_step = 1'b0;
        unique case (phase_reg)
            PH_KEY:
            begin
                new_val   = ta + key_b;
                mix_upd   = mix_reg + new_val;
                last_step = (step_reg == byte_t'(KEY_BYTES - 1));
            end
            PH_NONCE:
            begin
                new_val   = ta + nonce_b;
                mix_upd   = mix_reg + new_val;
                last_step = (step_reg == byte_t'(len_eff) - 8'd1);
            end
            PH_STIR1, PH_STIR2:
            begin
                new_val   = ta + mix_reg;
                mix_upd   = mix_reg + new_val + step_reg;
                last_step = (step_reg == byte_t'(TABLE_DEPTH - 1));
            end
            PH_SPREAD:
            begin
                new_val   = ta + tb + mix_reg;
                mix_upd   = mix_reg + ta + step_reg;
                last_step = (step_reg == byte_t'(SPREAD_LEN - 1));
            end
            PH_FINAL:
            begin
                new_val   = ta + tb + mix_reg;
                mix_upd   = mix_reg + new_val + step_reg;
                last_step = (step_reg == byte_t'(TABLE_DEPTH - 1));
            end
            PH_DATA:
            begin
                new_val   = ta + tb + mix_reg;
                mix_upd   = mix_reg + new_val + pos_reg;
                last_step = 1'b1;
            end
            default:
            begin
                new_val   = ta + tb + mix_reg;
                mix_upd   = mix_reg;
                last_step = 1'b1;
            end
        endcase
    end

    assign ks              = (mix_upd + new_val) ^ new_val;
    assign res_data        = data_reg ^ ks;
    assign tbl_req.wr_data = new_val;

    // A new transaction is taken when idle, or as a data byte finishes.
    assign item_ready = (state_reg == ST_IDLE) ||
                        (state_reg == ST_WRITE && phase_reg == PH_DATA && res_free);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        mix_next      = mix_reg;
        pos_next      = pos_reg;
        data_next     = data_reg;
        tbl_req.clear = 1'b0;
        tbl_req.we    = 1'b0;
        res_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                tbl_req.clear = 1'b1;
                mix_next      = '0;
                step_next     = '0;
                phase_next    = PH_KEY;
                state_next    = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (phase_reg == PH_DATA)
                begin
                    if (res_free)
                    begin
                        tbl_req.we = 1'b1;
                        mix_next   = mix_upd;
                        pos_next   = pos_reg + 8'd1;
                        res_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    tbl_req.we = 1'b1;
                    mix_next   = mix_upd;
                    state_next = ST_READ;
                    if (last_step)
                    begin
                        step_next = '0;
                        unique case (phase_reg)
                            PH_KEY:    phase_next = PH_STIR1;
                            PH_STIR1:  phase_next = (len_eff == '0) ? PH_STIR2 : PH_NONCE;
                            PH_NONCE:  phase_next = PH_STIR2;
                            PH_STIR2:  phase_next = PH_SPREAD;
                            PH_SPREAD: phase_next = PH_FINAL;
                            default:
                            begin
                                pos_next   = '0;
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        step_next = step_reg + 8'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            data_next = item_data;
            if (item_cmd == CMD_DATA)
            begin
                phase_next = PH_DATA;
                state_next = ST_READ;
            end
            else
            begin
                state_next = ST_CLEAR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
            step_reg  <= '0;
            mix_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            mix_reg   <= mix_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== src/btsc_checker.sv =====
// Port-level checks for the byte table stream cipher, bound to the top level.
// Depends on btsc_pkg and byte_table_stream_cipher.
`default_nettype none

module btsc_checker import btsc_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  item_valid,
    input wire logic  item_ready,
    input wire logic  item_cmd,
    input wire logic  result_valid,
    input wire logic  result_ready,
    input wire byte_t result_data
);

    logic accept;
    assign accept = item_valid && item_ready;

    // One transaction at a time: the cycle after acceptance is always busy.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !item_ready)
        else $error("item accepted in two consecutive cycles");

    // A rekey keeps the input closed well beyond a data byte's read and write steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_cmd == CMD_REKEY) |-> ##3 !item_ready)
        else $error("input reopened too early during rekey");

    // A fresh result only follows an accepted data transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(accept && item_cmd == CMD_DATA, 3))
        else $error("result without a matching data transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
        else $error("stalled result changed or dropped");

endmodule

bind byte_table_stream_cipher btsc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_cmd     (item.cmd),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data_out)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the byte table stream cipher: directed and random traffic
// against a predictor of the keystream, with random idling on both channels.
// Depends on btsc_pkg, the channel interfaces and the byte_table_stream_cipher top level.
`timescale 1ns / 100ps

module tb_top;
    import btsc_pkg::*;

    // Clock period and watchdog. Rekeys dominate the run time of the slowest
    // stimulus, and the watchdog sits many times above that run time.
    localparam int CLK_HALF_NS = 4;
    localparam int RESET_CYCLES = 12;
    localparam longint WATCHDOG_NS = 64'd10_000_000;

    // A rekey gives no result and keeps the block busy through every setup
    // pass, so settling time for the longest nonce is allowed before any
    // register write once the result queue has emptied.
    localparam int SETTLE_CYCLES = 2049 + 2 * NONCE_MAX + 64;

    // An index beyond the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam logic [WORD_W-1:0] WORD_ONES = '1;
    localparam logic [WORD_W-1:0] WORD_ZERO = '0;

    localparam int PRINT_CAP = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    btsc_item_if item_ch ();
    btsc_result_if result_ch ();

    byte_table_stream_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: the permutation table, the mixing accumulator, the
    // stream position and a copy of the configuration registers.
    // ------------------------------------------------------------------
    byte_t perm_tbl [TABLE_DEPTH];
    byte_t acc;
    byte_t pos;
    logic [WORD_W-1:0] key_w [KEY_WORDS];
    logic [WORD_W-1:0] nonce_w [NONCE_WORDS];
    logic [LEN_W-1:0] nonce_cnt;

    // Output bytes still owed by the block, oldest first.
    byte_t cipher_bytes_due [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Cycles for which the receiver is forced to hold off; counted down by
    // the receiver process itself.
    int hold_left = 0;
    byte_t due_byte;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // One stirring pass: the first 32 entries are folded with the accumulator
    // eight times over.
    function automatic void stir_table();
        int n;
        int s;
        for (n = 0; n < TABLE_DEPTH; n++)
        begin
            s = n % KEY_BYTES;
            perm_tbl[s] = perm_tbl[s] + acc;
            acc = acc + perm_tbl[s] + byte_t'(n);
        end
    endfunction

    // Full key schedule as run by a rekey command.
    function automatic void run_rekey();
        int n;
        int len;
        len = (nonce_cnt > NONCE_MAX) ? NONCE_MAX : int'(nonce_cnt);
        for (n = 0; n < TABLE_DEPTH; n++)
            perm_tbl[n] = '0;
        acc = '0;

        // Key bytes go into the first 32 entries.
        for (n = 0; n < KEY_BYTES; n++)
        begin
            perm_tbl[n] = perm_tbl[n] + key_w[n / 8][(n % 8) * BYTE_W +: BYTE_W];
            acc = acc + perm_tbl[n];
        end
        stir_table();

        // Nonce bytes are added over the start of the table.
        for (n = 0; n < len; n++)
        begin
            perm_tbl[n] = perm_tbl[n] + nonce_w[n / 8][(n % 8) * BYTE_W +: BYTE_W];
            acc = acc + perm_tbl[n];
        end
        stir_table();

        // Spread the keyed region over the rest of the table.
        for (n = 0; n < SPREAD_LEN; n++)
        begin
            perm_tbl[n + KEY_BYTES] = perm_tbl[n] + perm_tbl[(n + 1) % SPREAD_LEN] + acc;
            acc = acc + perm_tbl[n] + byte_t'(n);
        end

        // Final pass mixes each entry with the one half a table away.
        for (n = 0; n < TABLE_DEPTH; n++)
        begin
            perm_tbl[n] = perm_tbl[n] + perm_tbl[(n + HALF_TABLE) % TABLE_DEPTH] + acc;
            acc = acc + perm_tbl[n] + byte_t'(n);
        end
        pos = '0;
    endfunction

    // One data byte: update the entry at the position, then the accumulator,
    // and XOR the derived keystream byte onto the input.
    function automatic byte_t cipher_byte(input byte_t din);
        byte_t p;
        byte_t ks;
        p = pos;
        perm_tbl[p] = perm_tbl[p] + perm_tbl[byte_t'(p + 1)] + acc;
        acc = acc + perm_tbl[p] + p;
        ks = byte_t'(acc + perm_tbl[p]) ^ perm_tbl[p];
        pos = p + 8'd1;
        return din ^ ks;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: every rising edge, check an accepted result against the
    // oldest byte owed, then feed an accepted input transaction to the
    // predictor. Results trail their inputs through the read and write
    // steps, so the order of the two checks within one edge does not matter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (cipher_bytes_due.size() == 0)
                    report_error($sformatf("result transaction 0x%02h with none owed",
                                           result_ch.data_out));
                else
                begin
                    due_byte = cipher_bytes_due.pop_front();
                    if (result_ch.data_out !== due_byte)
                        report_error($sformatf("data_out 0x%02h, predicted 0x%02h",
                                               result_ch.data_out, due_byte));
                end
            end
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
            begin
                if (item_ch.cmd == CMD_DATA)
                    cipher_bytes_due.push_back(cipher_byte(item_ch.data_in));
                else
                    run_rekey();
            end
        end
    end

    // Receiver: ready changes on the falling edge, either held low for a
    // counted stretch or stalled at random at the current rate.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Register write: one cycle with the enable high, then low again. The
    // predictor's copy is updated to match; unmapped indexes change nothing.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_w[idx[1:0]] = value;
            REG_NONCE0, REG_NONCE1: nonce_w[idx[0]] = value;
            REG_NONCE_LEN: nonce_cnt = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one transaction, with random idle cycles in front of it, and
    // return at the rising edge that accepts it. Valid stays high into the
    // next call so that back-to-back transactions are possible.
    task automatic send_item(input cmd_t c, input byte_t d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.data_in <= d;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        item_ch.valid <= 1'b0;
    endtask

    // Wait until every owed result has arrived, then let a rekey that may
    // still be running finish, so that registers can be written safely.
    task automatic wait_idle();
        while (cipher_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_stream(input int unsigned n_bytes, input bit with_rekey);
        if (with_rekey)
            send_item(CMD_REKEY, byte_t'($urandom));
        repeat (n_bytes) send_item(CMD_DATA, byte_t'($urandom));
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(5);
        if (roll == 0)
            return WORD_ZERO;
        if (roll == 1)
            return WORD_ONES;
        return {$urandom, $urandom};
    endfunction

    // New key and nonce; the length is mostly legal but often above the
    // maximum, with random bits above the length field.
    task automatic load_random_key();
        logic [WORD_W-1:0] len_word;
        write_reg(REG_KEY0, pick_word());
        write_reg(REG_KEY1, pick_word());
        write_reg(REG_KEY2, pick_word());
        write_reg(REG_KEY3, pick_word());
        write_reg(REG_NONCE0, pick_word());
        write_reg(REG_NONCE1, pick_word());
        len_word = {$urandom, $urandom};
        if ($urandom_range(9) < 7)
            len_word[LEN_W-1:0] = LEN_W'($urandom_range(NONCE_MAX));
        else
            len_word[LEN_W-1:0] = LEN_W'($urandom_range(NONCE_MAX + 1, 31));
        write_reg(REG_NONCE_LEN, len_word);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Data straight after reset runs on the cleared table and accumulator.
    task automatic test_before_rekey();
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hff);
        send_item(CMD_DATA, 8'h5a);
        stop_sending();
        wait_idle();
    endtask

    // All-ones and all-zeros keys and nonces at the longest and the empty
    // nonce length.
    task automatic test_key_extremes();
        write_reg(REG_KEY0, WORD_ONES);
        write_reg(REG_KEY1, WORD_ONES);
        write_reg(REG_KEY2, WORD_ONES);
        write_reg(REG_KEY3, WORD_ONES);
        write_reg(REG_NONCE0, WORD_ONES);
        write_reg(REG_NONCE1, WORD_ONES);
        write_reg(REG_NONCE_LEN, WORD_W'(NONCE_MAX));
        send_item(CMD_REKEY, 8'hff);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hff);
        stop_sending();
        wait_idle();

        write_reg(REG_KEY0, WORD_ZERO);
        write_reg(REG_KEY1, WORD_ZERO);
        write_reg(REG_KEY2, WORD_ZERO);
        write_reg(REG_KEY3, WORD_ZERO);
        write_reg(REG_NONCE0, WORD_ZERO);
        write_reg(REG_NONCE1, WORD_ZERO);
        write_reg(REG_NONCE_LEN, WORD_ZERO);
        send_item(CMD_REKEY, 8'h00);
        send_item(CMD_DATA, 8'h80);
        send_item(CMD_DATA, 8'h01);
        stop_sending();
        wait_idle();
    endtask

    // Nonce lengths above the maximum are saturated, and only the low bits
    // of the written word form the length.
    task automatic test_nonce_len_saturation();
        write_reg(REG_NONCE0, 64'h0123_4567_89ab_cdef);
        write_reg(REG_NONCE1, 64'hfedc_ba98_7654_3210);
        write_reg(REG_NONCE_LEN, WORD_W'(31));
        send_item(CMD_REKEY, 8'h00);
        send_item(CMD_DATA, 8'h3c);
        stop_sending();
        wait_idle();
        write_reg(REG_NONCE_LEN, 64'hffff_ffff_ffff_ffe1);
        send_item(CMD_REKEY, 8'h00);
        send_item(CMD_DATA, 8'hc3);
        stop_sending();
        wait_idle();
    endtask

    // A write to an unmapped index leaves the key alone; back-to-back
    // rekeys then restart the stream twice.
    task automatic test_unmapped_index();
        write_reg(REG_UNMAPPED, WORD_ONES);
        send_item(CMD_REKEY, 8'haa);
        send_item(CMD_REKEY, 8'h55);
        send_item(CMD_DATA, 8'h7f);
        send_item(CMD_DATA, 8'hfe);
        stop_sending();
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering data, so the result register and the byte behind it fill and
    // the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 400;
        send_stream(24, 1'b0);
        stop_sending();
        wait_idle();
    endtask

    // Mostly well-formed traffic: a rekey followed by a run of data bytes,
    // now and then long enough to wrap the position. The rest continues a
    // stream without a rekey or throws in stray rekeys.
    task automatic test_random_traffic(input int target, input int send_pct, input int recv_pct);
        int sent;
        int unsigned roll;
        int unsigned len;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        load_random_key();
        sent = 0;
        while (sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                len = $urandom_range(250, 300);
            else
                len = $urandom_range(1, 40);
            if (roll < 75)
            begin
                send_stream(len, 1'b1);
                sent += len + 1;
            end
            else if (roll < 90)
            begin
                send_stream(len, 1'b0);
                sent += len;
            end
            else
            begin
                send_item(CMD_REKEY, byte_t'($urandom));
                sent++;
            end
        end
        stop_sending();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_DATA;
        item_ch.data_in = '0;

        // Predictor state after reset.
        for (int i = 0; i < TABLE_DEPTH; i++)
            perm_tbl[i] = '0;
        acc = '0;
        pos = '0;
        for (int i = 0; i < KEY_WORDS; i++)
            key_w[i] = '0;
        for (int i = 0; i < NONCE_WORDS; i++)
            nonce_w[i] = '0;
        nonce_cnt = LEN_W'(NONCE_MAX);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_before_rekey();
        test_key_extremes();
        test_nonce_len_saturation();
        test_unmapped_index();
        test_backpressure();
        test_random_traffic(325, 0, 0);
        test_random_traffic(325, 61, 0);
        test_random_traffic(325, 0, 61);
        test_random_traffic(325, 15, 15);

        // Every test ends idle; a final short settle catches any stray result.
        repeat (64) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
